// File: src/hsl2rgb_pkg.sv
// Shared types, widths and constants for the HSL to RGB converter.
// Used by hsl2rgb_chan and hsl_to_rgb_converter_top; no dependencies.
package hsl2rgb_pkg;

   localparam int unsigned HUE_W       = 9;
   localparam int unsigned PCT_W       = 7;
   localparam int unsigned FRAC_W      = 14;
   localparam int unsigned K_W         = 6;
   localparam int unsigned NUM_W       = 20;
   localparam int unsigned SCALED_W    = NUM_W + 4;
   localparam int unsigned Y_W         = 18;
   localparam int unsigned RECIP_W     = 19;
   localparam int unsigned PROD_W      = 36;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned RECIP_SHIFT = 28;
   localparam int unsigned Y_SHIFT     = 6;

   localparam logic [HUE_W-1:0] HUE_FULL       = 9'd360;
   localparam logic [HUE_W-1:0] HUE_SIXTH      = 9'd60;
   localparam logic [HUE_W-1:0] HUE_THIRD      = 9'd120;
   localparam logic [HUE_W-1:0] HUE_HALF       = 9'd180;
   localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 9'd240;

   localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

   localparam logic [K_W-1:0] K_FULL = 6'd60;

   // ceil(2^28 / 625); exact floor division for any 18-bit dividend.
   localparam logic [RECIP_W-1:0] RECIP_625 = 19'd429497;

   typedef logic [HUE_W-1:0]  hue_type;
   typedef logic [FRAC_W-1:0] frac_type;
   typedef logic [K_W-1:0]    ramp_k_type;
   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
   } stage_ctl_type;

   // Slope position of the hue ramp, in degrees, for a wrapped position t.
   function automatic ramp_k_type ramp_k(input hue_type t);
      ramp_k_type k;
      hue_type    diff;
      diff = HUE_TWO_THIRDS - t;
      if (t < HUE_SIXTH) begin
         k = t[K_W-1:0];
      end else if (t < HUE_HALF) begin
         k = K_FULL;
      end else if (t < HUE_TWO_THIRDS) begin
         k = diff[K_W-1:0];
      end else begin
         k = '0;
      end
      return k;
   endfunction

endpackage

// File: src/hsl2rgb_chan.sv
// One color channel of the converter: ramp numerator, scaling and the
// reciprocal multiply that yields the 8-bit value. Depends on hsl2rgb_pkg.
module hsl2rgb_chan
   import hsl2rgb_pkg::*;
(
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  frac_type      p_val,
   input  frac_type      d_val,
   input  ramp_k_type    k_val,
   output chan_type      chan_out
);

   logic [NUM_W-1:0]    num_in, num_ff;
   logic [SCALED_W-1:0] scaled;
   logic [Y_W-1:0]      y_in, y_ff;
   logic [PROD_W-1:0]   prod;
   chan_type            chan_in, chan_ff;

   // Numerator in units of 1/600000: 60*p + (q-p)*k.
   assign num_in = NUM_W'(p_val) * NUM_W'(K_FULL) + NUM_W'(d_val) * NUM_W'(k_val);

   // 255/600000 = 17/40000 = 17/(64*625); the 64 is a plain shift.
   assign scaled = {num_ff, 4'b0000} + SCALED_W'(num_ff);
   assign y_in   = scaled[Y_SHIFT+Y_W-1:Y_SHIFT];

   assign prod    = PROD_W'(y_ff) * PROD_W'(RECIP_625);
   assign chan_in = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         num_ff <= num_in;
      end
      if (ctl.en3) begin
         y_ff <= y_in;
      end
      if (ctl.en4) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_out = chan_ff;

endmodule

// File: src/hsl_to_rgb_converter_top.sv
// Top level of the HSL to RGB converter: input conditioning, p/q and hue
// ramp positions, then three hsl2rgb_chan lanes. Depends on hsl2rgb_pkg.
//
// Usage:
//   The req_ channel carries one pixel per beat: hue in degrees, saturation
//   and lightness in percent. The rsp_ channel returns one beat of 8-bit
//   red, green and blue for every request beat, in order.
//   A beat passes four register stages (p/q and ramp position, ramp
//   numerator, scaling, reciprocal multiply) before it shows on rsp_.
//   Throughput is one beat per clock while the receiver keeps rsp_ready
//   high; each stage takes one new beat per cycle as long as it is empty
//   or its content moves on.
//   Each stage holds its own valid bit. When the receiver drops rsp_ready,
//   the result stays on rsp_ and the earlier stages keep filling until
//   every stage is occupied; only then does req_ready fall.
//   Synchronous reset empties all stages; no result is shown until a new
//   beat has travelled the pipeline. No internal state survives a beat.
//
module hsl_to_rgb_converter_top
   import hsl2rgb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [HUE_W-1:0] req_hue_degrees,
   input  logic [PCT_W-1:0] req_saturation_pct,
   input  logic [PCT_W-1:0] req_lightness_pct,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output chan_type         rsp_red,
   output chan_type         rsp_green,
   output chan_type         rsp_blue
);

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic          rdy1, rdy2, rdy3, rdy4;
   stage_ctl_type ctl;

   hue_type          h_val, t_red, t_blue;
   logic [HUE_W:0]   t_red_sum;
   logic [PCT_W-1:0] s_val, l_val;
   logic [FRAC_W:0]  ls_prod, l100, s100, l200, q_wide, p_wide;
   frac_type         p_in, p_ff, d_in, d_ff;
   ramp_k_type       k_red_in, k_red_ff, k_green_in, k_green_ff, k_blue_in, k_blue_ff;

   // A stage may take new data when it is empty or its content moves on.
   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign ctl.en2 = rdy2 && v1_ff;
   assign ctl.en3 = rdy3 && v2_ff;
   assign ctl.en4 = rdy4 && v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // Input conditioning: one wrap of the hue, clamp of the percentages.
   always_comb begin
      h_val = (req_hue_degrees >= HUE_FULL) ? req_hue_degrees - HUE_FULL : req_hue_degrees;
      s_val = (req_saturation_pct > PCT_MAX) ? PCT_MAX : req_saturation_pct;
      l_val = (req_lightness_pct > PCT_MAX) ? PCT_MAX : req_lightness_pct;
   end

   // q and p in units of 1/10000; both stay within 0..10000 and q >= p.
   always_comb begin
      ls_prod = (FRAC_W+1)'(l_val) * (FRAC_W+1)'(s_val);
      l100    = (FRAC_W+1)'(l_val) * (FRAC_W+1)'(PCT_MAX);
      s100    = (FRAC_W+1)'(s_val) * (FRAC_W+1)'(PCT_MAX);
      l200    = {l100[FRAC_W-1:0], 1'b0};
      if (l_val < PCT_HALF) begin
         q_wide = l100 + ls_prod;
      end else begin
         q_wide = l100 + s100 - ls_prod;
      end
      p_wide = l200 - q_wide;
      p_in   = p_wide[FRAC_W-1:0];
      d_in   = q_wide[FRAC_W-1:0] - p_wide[FRAC_W-1:0];
   end

   // Ramp positions at h+120, h and h-120, each wrapped once. A red position
   // of exactly 360 is left alone and lands on the flat p part of the ramp.
   always_comb begin
      t_red_sum = {1'b0, h_val} + {1'b0, HUE_THIRD};
      if (t_red_sum > {1'b0, HUE_FULL}) begin
         t_red = t_red_sum[HUE_W-1:0] - HUE_FULL;
      end else begin
         t_red = t_red_sum[HUE_W-1:0];
      end
      t_blue     = (h_val < HUE_THIRD) ? h_val + HUE_TWO_THIRDS : h_val - HUE_THIRD;
      k_red_in   = ramp_k(t_red);
      k_green_in = ramp_k(h_val);
      k_blue_in  = ramp_k(t_blue);
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         p_ff       <= p_in;
         d_ff       <= d_in;
         k_red_ff   <= k_red_in;
         k_green_ff <= k_green_in;
         k_blue_ff  <= k_blue_in;
      end
   end

   hsl2rgb_chan u_red (
      .clock    (clock),
      .ctl      (ctl),
      .p_val    (p_ff),
      .d_val    (d_ff),
      .k_val    (k_red_ff),
      .chan_out (rsp_red)
   );

   hsl2rgb_chan u_green (
      .clock    (clock),
      .ctl      (ctl),
      .p_val    (p_ff),
      .d_val    (d_ff),
      .k_val    (k_green_ff),
      .chan_out (rsp_green)
   );

   hsl2rgb_chan u_blue (
      .clock    (clock),
      .ctl      (ctl),
      .p_val    (p_ff),
      .d_val    (d_ff),
      .k_val    (k_blue_ff),
      .chan_out (rsp_blue)
   );

   assign rsp_valid = v4_ff;

`ifndef SYNTHESIS
   // An accepted beat always lands in the first stage.
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted beat did not reach stage 1");

   // The output stage must not be overwritten while its beat is stalled.
   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !ctl.en4)
      else $error("stalled result overwritten");

   // Ramp positions never pass the full slope.
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (k_red_ff <= K_FULL) && (k_green_ff <= K_FULL) && (k_blue_ff <= K_FULL))
      else $error("ramp position out of range");

   // p stays within one, and so does q = p + d.
   a_pq_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ({1'b0, p_ff} + {1'b0, d_ff}) <= (FRAC_W+1)'(10000))
      else $error("p or q out of range");

   // Zero lightness gives black: both p and q are zero.
   a_black: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_lightness_pct == '0) |=> (p_ff == '0) && (d_ff == '0))
      else $error("zero lightness not black");
`endif

endmodule
